// File: rtl/complex_alu_defines.svh
// assertion macros shared by the rtl
`ifndef COMPLEX_ALU_DEFINES_SVH
`define COMPLEX_ALU_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define CXA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define CXA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/cxa_pkg.sv
package cxa_pkg;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_EQ  = 3'd4
  } op_t;

  localparam int DIV_STEPS = 32;

  localparam logic signed [64:0] POS_LIM = 65'sd2147483647;
  localparam logic signed [64:0] NEG_LIM = -65'sd2147483648;

  typedef struct packed {
    logic [31:0] val;
    logic        ov;
  } sat_t;

  // products and short sums after the first stage
  typedef struct packed {
    logic [2:0]         func;
    logic signed [63:0] p_rr;
    logic signed [63:0] p_ii;
    logic signed [63:0] p_ri;
    logic signed [63:0] p_ir;
    logic [63:0]        d_r;
    logic [63:0]        d_i;
    logic signed [32:0] sum_re;
    logic signed [32:0] sum_im;
    logic               eq;
  } prod_t;

  // combined cross terms and divisor
  typedef struct packed {
    logic [2:0]         func;
    logic signed [64:0] s_re;
    logic signed [64:0] s_im;
    logic [63:0]        den;
    logic signed [32:0] sum_re;
    logic signed [32:0] sum_im;
    logic               eq;
  } sum_t;

  // record carried through the divider steps
  typedef struct packed {
    logic        is_div;
    logic        dz;
    logic        eq;
    logic        ov;
    logic [31:0] res_re;
    logic [31:0] res_im;
    logic        neg_re;
    logic        neg_im;
    logic        sat_re;
    logic        sat_im;
    logic [63:0] den;
    logic [63:0] r_re;
    logic [63:0] r_im;
    logic [31:0] sh_re;
    logic [31:0] sh_im;
    logic [31:0] q_re;
    logic [31:0] q_im;
  } div_t;

  function automatic sat_t sat65(input logic signed [64:0] v);
    sat_t s;
    if (v > POS_LIM) begin
      s.val = 32'h7FFF_FFFF;
      s.ov  = 1'b1;
    end else if (v < NEG_LIM) begin
      s.val = 32'h8000_0000;
      s.ov  = 1'b1;
    end else begin
      s.val = v[31:0];
      s.ov  = 1'b0;
    end
    return s;
  endfunction

  function automatic sat_t sat_quot(input logic neg, input logic big, input logic [31:0] q);
    sat_t s;
    if (big) begin
      s.val = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      s.ov  = 1'b1;
    end else if (!neg) begin
      s.val = q[31] ? 32'h7FFF_FFFF : q;
      s.ov  = q[31];
    end else if (q > 32'h8000_0000) begin
      s.val = 32'h8000_0000;
      s.ov  = 1'b1;
    end else begin
      s.val = 32'(-q);
      s.ov  = 1'b0;
    end
    return s;
  endfunction

endpackage

// File: rtl/cxa_in_if.sv
interface cxa_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         func;
  logic signed [31:0] a_re;
  logic signed [31:0] a_im;
  logic signed [31:0] b_re;
  logic signed [31:0] b_im;

  modport source (output valid, func, a_re, a_im, b_re, b_im, input ready);
  modport sink (input valid, func, a_re, a_im, b_re, b_im, output ready);
endinterface

// File: rtl/cxa_out_if.sv
interface cxa_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] res_re;
  logic signed [31:0] res_im;
  logic               equal;
  logic               div_zero;
  logic               overflow;

  modport source (output valid, res_re, res_im, equal, div_zero, overflow, input ready);
  modport sink (input valid, res_re, res_im, equal, div_zero, overflow, output ready);
endinterface

// File: rtl/cxa_mult.sv
module cxa_mult (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               vin,
  input  logic [2:0]         func,
  input  logic signed [31:0] a_re,
  input  logic signed [31:0] a_im,
  input  logic signed [31:0] b_re,
  input  logic signed [31:0] b_im,
  output logic               v_r,
  output cxa_pkg::prod_t     prod_r
);
  import cxa_pkg::*;

  prod_t prod_nxt;

  always_comb begin
    prod_nxt.func = func;
    prod_nxt.p_rr = 64'(a_re) * 64'(b_re);
    prod_nxt.p_ii = 64'(a_im) * 64'(b_im);
    prod_nxt.p_ri = 64'(a_re) * 64'(b_im);
    prod_nxt.p_ir = 64'(a_im) * 64'(b_re);
    prod_nxt.d_r  = 64'(64'(b_re) * 64'(b_re));
    prod_nxt.d_i  = 64'(64'(b_im) * 64'(b_im));
    if (func == OP_SUB) begin
      prod_nxt.sum_re = 33'(a_re) - 33'(b_re);
      prod_nxt.sum_im = 33'(a_im) - 33'(b_im);
    end else begin
      prod_nxt.sum_re = 33'(a_re) + 33'(b_re);
      prod_nxt.sum_im = 33'(a_im) + 33'(b_im);
    end
    prod_nxt.eq = (a_re == b_re) && (a_im == b_im);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end
endmodule

// File: rtl/cxa_comb.sv
module cxa_comb #(
  parameter int FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           vin,
  input  cxa_pkg::prod_t prod,
  output logic           v_r,
  output cxa_pkg::div_t  rec_r
);
  import cxa_pkg::*;

  sum_t sum_r;
  sum_t sum_nxt;
  logic sv_r;
  div_t rec_nxt;
  sat_t s_re;
  sat_t s_im;
  logic [63:0] m_re;
  logic [63:0] m_im;

  // cross terms and divisor
  always_comb begin
    sum_nxt.func   = prod.func;
    sum_nxt.den    = prod.d_r + prod.d_i;
    sum_nxt.sum_re = prod.sum_re;
    sum_nxt.sum_im = prod.sum_im;
    sum_nxt.eq     = prod.eq;
    case (prod.func)
      OP_MUL: begin
        sum_nxt.s_re = 65'(prod.p_rr) - 65'(prod.p_ii);
        sum_nxt.s_im = 65'(prod.p_ri) + 65'(prod.p_ir);
      end
      OP_DIV: begin
        sum_nxt.s_re = 65'(prod.p_rr) + 65'(prod.p_ii);
        sum_nxt.s_im = 65'(prod.p_ir) - 65'(prod.p_ri);
      end
      default: begin
        sum_nxt.s_re = '0;
        sum_nxt.s_im = '0;
      end
    endcase
  end

  // simple results and divider setup
  always_comb begin
    s_re = '0;
    s_im = '0;
    case (sum_r.func)
      OP_ADD, OP_SUB: begin
        s_re = sat65(65'(sum_r.sum_re));
        s_im = sat65(65'(sum_r.sum_im));
      end
      OP_MUL: begin
        s_re = sat65(sum_r.s_re >>> FRAC_BITS);
        s_im = sat65(sum_r.s_im >>> FRAC_BITS);
      end
      default: begin
        s_re = '0;
        s_im = '0;
      end
    endcase
    m_re = sum_r.s_re[64] ? 64'(-sum_r.s_re) : sum_r.s_re[63:0];
    m_im = sum_r.s_im[64] ? 64'(-sum_r.s_im) : sum_r.s_im[63:0];

    rec_nxt.is_div = (sum_r.func == OP_DIV);
    rec_nxt.dz     = (sum_r.func == OP_DIV) && (sum_r.den == 64'd0);
    rec_nxt.eq     = (sum_r.func == OP_EQ) && sum_r.eq;
    rec_nxt.ov     = s_re.ov | s_im.ov;
    rec_nxt.res_re = s_re.val;
    rec_nxt.res_im = s_im.val;
    rec_nxt.neg_re = sum_r.s_re[64];
    rec_nxt.neg_im = sum_r.s_im[64];
    rec_nxt.den    = sum_r.den;
    rec_nxt.r_re   = m_re >> (32 - FRAC_BITS);
    rec_nxt.r_im   = m_im >> (32 - FRAC_BITS);
    rec_nxt.sat_re = (m_re >> (32 - FRAC_BITS)) >= sum_r.den;
    rec_nxt.sat_im = (m_im >> (32 - FRAC_BITS)) >= sum_r.den;
    rec_nxt.sh_re  = 32'(m_re << FRAC_BITS);
    rec_nxt.sh_im  = 32'(m_im << FRAC_BITS);
    rec_nxt.q_re   = '0;
    rec_nxt.q_im   = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r <= 1'b0;
      v_r  <= 1'b0;
    end else if (en) begin
      sv_r <= vin;
      v_r  <= sv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= sum_nxt;
      rec_r <= rec_nxt;
    end
  end
endmodule

// File: rtl/cxa_div_step.sv
module cxa_div_step (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          vin,
  input  cxa_pkg::div_t din,
  output logic          v_r,
  output cxa_pkg::div_t dout_r
);
  import cxa_pkg::*;

  div_t        dout_nxt;
  logic [64:0] t_re;
  logic [64:0] t_im;
  logic [64:0] d_re;
  logic [64:0] d_im;
  logic        ge_re;
  logic        ge_im;

  // one restoring quotient bit per part
  always_comb begin
    t_re  = {din.r_re, din.sh_re[31]};
    t_im  = {din.r_im, din.sh_im[31]};
    d_re  = t_re - {1'b0, din.den};
    d_im  = t_im - {1'b0, din.den};
    ge_re = t_re >= {1'b0, din.den};
    ge_im = t_im >= {1'b0, din.den};

    dout_nxt       = din;
    dout_nxt.r_re  = ge_re ? d_re[63:0] : t_re[63:0];
    dout_nxt.r_im  = ge_im ? d_im[63:0] : t_im[63:0];
    dout_nxt.sh_re = din.sh_re << 1;
    dout_nxt.sh_im = din.sh_im << 1;
    dout_nxt.q_re  = {din.q_re[30:0], ge_re};
    dout_nxt.q_im  = {din.q_im[30:0], ge_im};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout_r <= dout_nxt;
    end
  end
endmodule

// File: rtl/complex_alu.sv
// channel   modport  signals
// in_ch     sink     valid ready func a_re a_im b_re b_im
// out_ch    source   valid ready res_re res_im equal div_zero overflow
//
// one request per cycle while the output is not stalled; every func code takes the same path through the pipe
// stages: products, cross sums, setup, 32 quotient bit steps, output register
// the quotient steps (one bit per stage) set the latency
// rst_n is synchronous and clears only the valid bits
// a stalled output freezes the whole pipe; in_ch.ready falls only then
`include "complex_alu_defines.svh"

module complex_alu #(
  parameter int FRAC_BITS = 16
) (
  input logic      clk,
  input logic      rst_n,
  cxa_in_if.sink   in_ch,
  cxa_out_if.source out_ch
);
  import cxa_pkg::*;

  logic               en;
  logic               m_v;
  prod_t              m_d;
  logic               c_v;
  div_t               c_d;
  logic               st_v [DIV_STEPS+1];
  div_t               st_d [DIV_STEPS+1];
  div_t               last;
  sat_t               f_re;
  sat_t               f_im;
  logic               out_valid_r;
  logic [31:0]        res_re_r;
  logic [31:0]        res_im_r;
  logic               equal_r;
  logic               div_zero_r;
  logic               overflow_r;
  logic [31:0]        res_re_nxt;
  logic [31:0]        res_im_nxt;
  logic               overflow_nxt;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  cxa_mult u_mult (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vin    (in_ch.valid),
    .func   (in_ch.func),
    .a_re   (in_ch.a_re),
    .a_im   (in_ch.a_im),
    .b_re   (in_ch.b_re),
    .b_im   (in_ch.b_im),
    .v_r    (m_v),
    .prod_r (m_d)
  );

  cxa_comb #(.FRAC_BITS(FRAC_BITS)) u_comb (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vin   (m_v),
    .prod  (m_d),
    .v_r   (c_v),
    .rec_r (c_d)
  );

  assign st_v[0] = c_v;
  assign st_d[0] = c_d;

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
    cxa_div_step u_step (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .vin    (st_v[i]),
      .din    (st_d[i]),
      .v_r    (st_v[i+1]),
      .dout_r (st_d[i+1])
    );
  end

  assign last = st_d[DIV_STEPS];

  always_comb begin
    f_re = sat_quot(last.neg_re, last.sat_re, last.q_re);
    f_im = sat_quot(last.neg_im, last.sat_im, last.q_im);
    if (last.dz) begin
      res_re_nxt   = '0;
      res_im_nxt   = '0;
      overflow_nxt = 1'b0;
    end else if (last.is_div) begin
      res_re_nxt   = f_re.val;
      res_im_nxt   = f_im.val;
      overflow_nxt = f_re.ov | f_im.ov;
    end else begin
      res_re_nxt   = last.res_re;
      res_im_nxt   = last.res_im;
      overflow_nxt = last.ov;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= st_v[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_re_r   <= res_re_nxt;
      res_im_r   <= res_im_nxt;
      equal_r    <= last.eq;
      div_zero_r <= last.dz;
      overflow_r <= overflow_nxt;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.res_re   = res_re_r;
  assign out_ch.res_im   = res_im_r;
  assign out_ch.equal    = equal_r;
  assign out_ch.div_zero = div_zero_r;
  assign out_ch.overflow = overflow_r;

  `CXA_ASSERT_IMP(a_dz_clean, out_ch.valid && out_ch.div_zero, (out_ch.res_re == 0) && (out_ch.res_im == 0) && !out_ch.overflow && !out_ch.equal, "divide fault with nonzero result")
  `CXA_ASSERT_IMP(a_eq_clean, out_ch.valid && out_ch.equal, (out_ch.res_re == 0) && (out_ch.res_im == 0) && !out_ch.overflow, "equality test with nonzero result")
  `CXA_ASSERT_IMP(a_stall_only, !in_ch.ready, out_ch.valid && !out_ch.ready, "input blocked without output stall")
  `CXA_ASSERT_NXT(a_drain, out_ch.valid && out_ch.ready && !st_v[DIV_STEPS], !out_ch.valid, "output valid without a request behind it")
endmodule

// File: tb/complex_alu_checker.sv
module complex_alu_checker #(
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  cxa_in_if    in_ch,
  cxa_out_if   out_ch,
  output int   errors,
  output int   pending,
  output int   n_results
);
  timeunit 1ns;
  timeprecision 1ps;
  import cxa_pkg::*;

  typedef struct packed {
    logic [31:0] re;
    logic [31:0] im;
    logic        eq;
    logic        dz;
    logic        ov;
  } cx_result_t;

  cx_result_t results_due[$];

  function automatic logic [31:0] clamp32(input logic signed [127:0] v, inout logic ov);
    if (v > 128'sh7FFF_FFFF) begin
      ov = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (v < -128'sh8000_0000) begin
      ov = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  // quotient truncated toward zero
  function automatic logic signed [127:0] qdiv(input logic signed [127:0] n,
                                               input logic signed [127:0] d);
    logic signed [127:0] m;
    logic signed [127:0] q;
    m = (n < 0) ? -n : n;
    q = (m <<< FRAC_BITS) / d;
    return (n < 0) ? -q : q;
  endfunction

  function automatic cx_result_t cx_compute(input logic [2:0] func,
                                            input logic signed [31:0] a_re, a_im,
                                            input logic signed [31:0] b_re, b_im);
    cx_result_t r;
    logic signed [127:0] ar, ai, br, bi, den;
    logic ov;
    ar = a_re;
    ai = a_im;
    br = b_re;
    bi = b_im;
    r = '0;
    ov = 1'b0;
    case (func)
      OP_ADD: begin
        r.re = clamp32(ar + br, ov);
        r.im = clamp32(ai + bi, ov);
      end
      OP_SUB: begin
        r.re = clamp32(ar - br, ov);
        r.im = clamp32(ai - bi, ov);
      end
      OP_MUL: begin
        r.re = clamp32((ar * br - ai * bi) >>> FRAC_BITS, ov);
        r.im = clamp32((ar * bi + ai * br) >>> FRAC_BITS, ov);
      end
      OP_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.dz = 1'b1;
        end else begin
          r.re = clamp32(qdiv(ar * br + ai * bi, den), ov);
          r.im = clamp32(qdiv(ai * br - ar * bi, den), ov);
        end
      end
      OP_EQ: begin
        r.eq = (a_re == b_re) && (a_im == b_im);
      end
      default: begin
      end
    endcase
    r.ov = ov;
    return r;
  endfunction

  assign pending = results_due.size();

  always @(posedge clk) begin
    cx_result_t got, want;
    if (!rst_n) begin
      results_due.delete();
      errors <= 0;
      n_results <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        results_due.push_back(cx_compute(in_ch.func, in_ch.a_re, in_ch.a_im,
                                         in_ch.b_re, in_ch.b_im));
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.res_re, out_ch.res_im, out_ch.equal, out_ch.div_zero,
                out_ch.overflow};
        n_results <= n_results + 1;
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result re=%h im=%h eq=%b dz=%b ov=%b", $time,
                   got.re, got.im, got.eq, got.dz, got.ov);
          errors <= errors + 1;
        end else begin
          want = results_due.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected re=%h im=%h eq=%b dz=%b ov=%b", $time,
                     want.re, want.im, want.eq, want.dz, want.ov);
            $display("%0t:          actual   re=%h im=%h eq=%b dz=%b ov=%b", $time,
                     got.re, got.im, got.eq, got.dz, got.ov);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

// File: tb/complex_alu_tb.sv
module complex_alu_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cxa_pkg::*;

  localparam int STALL_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   errors, pending, n_results;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   hold_cycles = 0;
  int   idle_count = 0;
  int   n_requests = 0;

  cxa_in_if  in_ch ();
  cxa_out_if out_ch ();

  complex_alu #(.FRAC_BITS(16)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  complex_alu_checker #(.FRAC_BITS(16)) i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .errors    (errors),
    .pending   (pending),
    .n_results (n_results)
  );

  always #4 clk = ~clk;

  // receiver side, long hold-off counted here
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        hold_cycles = hold_cycles - 1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_count <= 0;
    end else begin
      idle_count <= idle_count + 1;
      if (idle_count >= STALL_LIMIT) begin
        $display("timeout after %0d cycles with no progress", STALL_LIMIT);
        $display("complex_alu_tb failed");
        $finish;
      end
    end
  end

  task automatic send_request(input logic [2:0] func, input logic [31:0] a_re, a_im,
                              input logic [31:0] b_re, b_im);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.func  <= func;
    in_ch.a_re  <= a_re;
    in_ch.a_im  <= a_im;
    in_ch.b_re  <= b_re;
    in_ch.b_im  <= b_im;
    do @(posedge clk); while (!in_ch.ready);
    n_requests++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(5))
      0: case ($urandom_range(5))
           0: return 32'h0;
           1: return 32'h7FFF_FFFF;
           2: return 32'h8000_0000;
           3: return 32'hFFFF_FFFF;
           4: return 32'h0001_0000;
           default: return 32'h1;
         endcase
      1, 2: return 32'($signed($urandom_range(2097152)) - 1048576);
      3: return 32'($signed($urandom_range(65536)) - 32768);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random();
    logic [2:0]  func;
    logic [31:0] ar, ai, br, bi;
    func = ($urandom_range(19) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(4));
    ar = pick_word();
    ai = pick_word();
    br = pick_word();
    bi = pick_word();
    if (func == OP_EQ && $urandom_range(1)) begin
      br = ar;
      bi = ($urandom_range(3) == 0) ? ai ^ (32'h1 << $urandom_range(31)) : ai;
    end
    if (func == OP_DIV && $urandom_range(15) == 0) begin
      br = '0;
      bi = '0;
    end
    send_request(func, ar, ai, br, bi);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.func  = OP_ADD;
    in_ch.a_re  = '0;
    in_ch.a_im  = '0;
    in_ch.b_re  = '0;
    in_ch.b_im  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed
    send_request(OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'hFFFF_FFFF);
    send_request(OP_ADD, 32'h0001_0000, 32'hFFFF_0000, 32'h0002_8000, 32'h0);
    send_request(OP_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 32'hFFFF_FFFF);
    send_request(OP_SUB, 32'h0003_0000, 32'h0, 32'h0001_0000, 32'h0001_0000);
    send_request(OP_MUL, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 32'hFFFF_0000);
    send_request(OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(OP_MUL, 32'h8000_0000, 32'h0, 32'h8000_0000, 32'h0);
    send_request(OP_MUL, 32'hFFFF_FFFF, 32'h0, 32'h1, 32'h0);
    send_request(OP_DIV, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0);
    send_request(OP_DIV, 32'h0004_0000, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000);
    send_request(OP_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'h0);
    send_request(OP_DIV, 32'hFFFF_FFFF, 32'h0, 32'h0003_0000, 32'h0);
    send_request(OP_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_request(OP_EQ, 32'h1234_5678, 32'h8000_0000, 32'h1234_5678, 32'h8000_0000);
    send_request(OP_EQ, 32'h1234_5678, 32'h8000_0000, 32'h1234_5678, 32'h8000_0001);
    send_request(OP_EQ, 32'h0, 32'h0, 32'h0, 32'h0);
    send_request(3'd5, 32'h7FFF_FFFF, 32'h1, 32'h2, 32'h3);
    send_request(3'd6, 32'h0, 32'h0, 32'h0, 32'h0);
    send_request(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain();

    // long receiver hold-off while the sender keeps offering
    hold_cycles = 300;
    repeat (120) send_random();
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      repeat (170) send_random();
      if (phase % 2) drain();
    end
    drain();
    repeat (50) @(posedge clk);

    $display("sent %0d requests over all ops, saturating and divide-by-zero cases,", n_requests);
    $display("checked %0d results under mixed idle and stall patterns", n_results);
    if (errors == 0 && pending == 0) begin
      $display("complex_alu_tb passed");
    end else begin
      $display("complex_alu_tb failed");
    end
    $finish;
  end
endmodule
